// File: rtl/ksb_pkg.sv
// ============================================================================
// ksb_pkg
// Shared types and codes for the shared-buffer stack block: request/result
// payloads, status codes, controller states and the controller/datapath link.
// ============================================================================
package ksb_pkg;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // value reported when nothing was popped
    localparam logic signed [31:0] NO_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         stack_id;
        logic signed [31:0] push_value;
    } ksb_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
        logic               full_now;
    } ksb_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_POP_RD,
        ST_POP_WR
    } ksb_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // request taken this cycle
        logic push_go;  // push accepted, store the value now
        logic reject;   // error result straight from the request
        logic push_wr;  // push link/head update cycle
        logic pop_rd;   // pop: head known, read link and value
        logic pop_wr;   // pop link/head update cycle
    } ksb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic push_ok;
        logic pop_ok;
    } ksb_stat_t;

endpackage

// File: rtl/ksb_ram.sv
// ============================================================================
// ksb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ksb_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ksb_ctrl.sv
// ============================================================================
// ksb_ctrl
// Operation sequencer: takes a request and either rejects it or steps the
// datapath through the read and update cycles of a push or a pop.
// ============================================================================
module ksb_ctrl
    import ksb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ksb_stat_t stat,
    output logic      busy,
    output ksb_cmd_t  cmd
);

    ksb_state_t state_reg;
    ksb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    priority if (stat.push_ok)
                        state_next = ST_PUSH_WR;
                    else if (stat.pop_ok)
                        state_next = ST_POP_RD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_PUSH_WR: state_next = ST_IDLE;
            ST_POP_RD:  state_next = ST_POP_WR;
            ST_POP_WR:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.accept  = start;
                cmd.push_go = start & stat.push_ok;
                cmd.reject  = start & ~stat.push_ok & ~stat.pop_ok;
            end
            ST_PUSH_WR: cmd.push_wr = 1'b1;
            ST_POP_RD:  cmd.pop_rd  = 1'b1;
            ST_POP_WR:  cmd.pop_wr  = 1'b1;
            default:    busy        = 1'b1;
        endcase
    end

endmodule

// File: rtl/ksb_datapath.sv
// ============================================================================
// ksb_datapath
// Slot store, link store and stack head store, free list head, fill mark and
// result register. Slots at or above the fill mark were never written and
// link to the next slot in order.
// ============================================================================
module ksb_datapath
    import ksb_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  ksb_req_t  request,
    input  ksb_cmd_t  cmd,
    output ksb_stat_t stat,
    output logic      done,
    output ksb_rsp_t  result
);

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int LINK_W = $clog2(NUM_SLOTS + 1);
    localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

    logic [LINK_W-1:0]     free_head_reg, free_head_next;
    logic [LINK_W-1:0]     fill_reg, fill_next;
    logic [NUM_STACKS-1:0] nonempty_reg, nonempty_next;
    logic [SID_W-1:0]      sid_reg;
    logic [ADDR_W-1:0]     slot_reg;
    logic                  fresh_reg;
    logic [LINK_W-1:0]     fresh_link_reg;
    ksb_rsp_t              result_reg, result_next;
    logic                  done_reg;

    logic [SID_W-1:0]  req_sid;
    logic              sid_ok;
    logic              free_null;

    logic              link_we;
    logic [ADDR_W-1:0] link_waddr, link_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata, link_out;

    logic              head_we;
    logic [SID_W-1:0]  head_waddr, head_raddr;
    logic [ADDR_W-1:0] head_wdata, head_rdata;

    logic [31:0]       value_rdata;
    logic [LINK_W-1:0] old_head;

    assign req_sid   = SID_W'(request.stack_id);
    assign sid_ok    = 32'(request.stack_id) < NUM_STACKS;
    assign free_null = (free_head_reg == NULL_LINK);

    assign stat.push_ok = (request.opcode == OP_PUSH) && sid_ok && !free_null;
    assign stat.pop_ok  = (request.opcode == OP_POP) && sid_ok && nonempty_reg[req_sid];

    // link read: unwritten slots follow the reset chain
    assign link_raddr = cmd.pop_rd ? head_rdata : free_head_reg[ADDR_W-1:0];
    assign link_out   = fresh_reg ? fresh_link_reg : link_rdata;
    assign head_raddr = cmd.accept ? req_sid : sid_reg;
    assign old_head   = nonempty_reg[sid_reg] ? LINK_W'(head_rdata) : NULL_LINK;

    always_comb
    begin
        link_we    = cmd.push_wr | cmd.pop_wr;
        link_waddr = cmd.push_wr ? free_head_reg[ADDR_W-1:0] : slot_reg;
        link_wdata = cmd.push_wr ? old_head : free_head_reg;
        head_we    = cmd.push_wr | cmd.pop_wr;
        head_waddr = sid_reg;
        head_wdata = cmd.push_wr ? free_head_reg[ADDR_W-1:0] : link_out[ADDR_W-1:0];
    end

    ksb_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ksb_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_STACKS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    ksb_ram #(
        .WIDTH (32),
        .DEPTH (NUM_SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.push_go),
        .waddr (free_head_reg[ADDR_W-1:0]),
        .wdata (request.push_value),
        .raddr (head_rdata),
        .rdata (value_rdata)
    );

    always_comb
    begin
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        nonempty_next  = nonempty_reg;
        result_next    = result_reg;
        if (cmd.reject)
        begin
            result_next.status    = (request.opcode == OP_PUSH) ? STATUS_OVERFLOW
                                                                : STATUS_UNDERFLOW;
            result_next.pop_value = NO_VALUE;
            result_next.full_now  = free_null;
        end
        if (cmd.push_wr)
        begin
            free_head_next         = link_out;
            nonempty_next[sid_reg] = 1'b1;
            if (free_head_reg == fill_reg)
            begin
                fill_next = fill_reg + LINK_W'(1);
            end
            result_next.status    = STATUS_OK;
            result_next.pop_value = NO_VALUE;
            result_next.full_now  = (link_out == NULL_LINK);
        end
        if (cmd.pop_wr)
        begin
            free_head_next         = LINK_W'(slot_reg);
            nonempty_next[sid_reg] = (link_out != NULL_LINK);
            result_next.status     = STATUS_OK;
            result_next.pop_value  = value_rdata;
            result_next.full_now   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            nonempty_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            nonempty_reg  <= nonempty_next;
            done_reg      <= cmd.reject | cmd.push_wr | cmd.pop_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        fresh_reg      <= (LINK_W'(link_raddr) >= fill_reg);
        fresh_link_reg <= LINK_W'(link_raddr) + LINK_W'(1);
        if (cmd.accept)
        begin
            sid_reg <= req_sid;
        end
        if (cmd.pop_rd)
        begin
            slot_reg <= head_rdata;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NULL_LINK)
        else $error("fill mark past the slot count");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NULL_LINK)
        else $error("free list head past null");

    a_alloc_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_wr |-> free_head_reg <= fill_reg)
        else $error("allocated slot skips the fill mark");

    a_pop_written: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_wr |-> LINK_W'(slot_reg) < fill_reg && !fresh_reg)
        else $error("pop of a never written slot");

endmodule

// File: rtl/k_stacks_shared_buffer.sv
// ============================================================================
// k_stacks_shared_buffer
// Several linked stacks kept in one shared slot store with a linked free list.
// ============================================================================
// Usage:
//   Request channel: drive request (opcode, stack_id, push_value) and raise
//   start; the transfer happens at a rising edge where start is high and
//   busy is low. busy stays high while an operation is in flight.
//   Result channel: done is high for exactly one cycle with result (status,
//   pop_value, full_now) valid. The receiver cannot stall; each result must
//   be taken in the cycle it is shown.
//   Steps from the request transfer edge to done:
//     rejected operation (overflow / underflow)  done and result registered from the request
//     push                                       state ST_PUSH_WR, then done
//     pop                                        states ST_POP_RD and ST_POP_WR, then done
//   A new request may be transferred in the cycle done is high; the block
//   takes no new operation before the last one is through. The steps are set
//   by the registered-read memories: a push reads the free slot's link, a pop
//   reads the stack head and then the link and value of that slot.
//   Reset: all stacks empty, free list chains slots in order from slot 0.
//   No memory clearing pass: never-written slots follow the reset chain by
//   comparison with a fill mark, so requests are taken right after reset.
// ============================================================================
module k_stacks_shared_buffer
    import ksb_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ksb_req_t request,
    output logic     busy,
    output logic     done,
    output ksb_rsp_t result
);

    ksb_cmd_t  cmd;
    ksb_stat_t stat;

    // sequencer: decides accept/reject and steps the update cycles
    ksb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // storage and result register
    ksb_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule
